// ===== sv/cfrf_pkg.sv =====
// shared types and constants for the can frame radio framer
`default_nettype none
package cfrf_pkg;

  localparam int HDR_BYTES     = 5;
  localparam int PAYLOAD_BYTES = 15;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;

  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [7:0] REJ_BYTE  = 8'h00;

  // one classified frame, ready for the serialiser
  typedef struct packed {
    logic                               rejected;
    logic [2:0]                         hdr_cnt;
    logic [4:0]                         total;
    logic [HDR_BYTES-1:0][7:0]          hdr;
    logic [PAYLOAD_BYTES-1:0][7:0]      data;
  } desc_t;

endpackage
`default_nettype wire

// ===== sv/cfrf_front.sv =====
// front end: length check, extended id chunking and header build
`default_nettype none
module cfrf_front
  import cfrf_pkg::*;
#(
  parameter int MAX_STD_DATA      = 8,
  parameter int MAX_OVERSIZE_DATA = 15
) (
  input  wire logic [10:0] base_id,
  input  wire logic [17:0] ext_id,
  input  wire logic [4:0]  data_len,
  input  wire logic [63:0] data_low,
  input  wire logic [55:0] data_high,
  input  wire logic        allow_oversize,
  output desc_t            desc
);

  localparam logic [4:0] STD_LIM = 5'(MAX_STD_DATA);
  localparam logic [4:0] OVR_LIM = 5'(MAX_OVERSIZE_DATA);

  logic [4:0] limit;
  logic [1:0] ext_cnt;
  logic [3:0] len;

  always_comb begin
    limit = allow_oversize ? OVR_LIM : STD_LIM;
    len   = data_len[3:0];
    if (ext_id == 18'd0) begin
      ext_cnt = 2'd0;
    end else if (ext_id[17:7] == 11'd0) begin
      ext_cnt = 2'd1;
    end else if (ext_id[17:14] == 4'd0) begin
      ext_cnt = 2'd2;
    end else begin
      ext_cnt = 2'd3;
    end

    desc.rejected = (data_len > limit);
    desc.hdr_cnt  = 3'd2 + {1'b0, ext_cnt};
    desc.total    = 5'd2 + {3'b0, ext_cnt} + {1'b0, len};
    desc.hdr[0]   = base_id[7:0];
    desc.hdr[1]   = {(ext_cnt != 2'd0), len, base_id[10:8]};
    // least significant chunk first, continuation bit when more follow
    desc.hdr[2]   = {(ext_cnt > 2'd1), ext_id[6:0]};
    desc.hdr[3]   = {(ext_cnt > 2'd2), ext_id[13:7]};
    desc.hdr[4]   = {4'b0, ext_id[17:14]};
    desc.data     = {data_high, data_low};
  end

endmodule
`default_nettype wire

// ===== sv/cfrf_queue.sv =====
// two-entry descriptor queue between front and back
`default_nettype none
module cfrf_queue
  import cfrf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t wr_desc,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output desc_t      rd_desc
);

  desc_t             entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_comb begin
    full      = (count == (QPTR_W+1)'(QDEPTH));
    not_empty = (count != '0);
    rd_desc   = entry[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wr_desc;
  end

endmodule
`default_nettype wire

// ===== sv/cfrf_back.sv =====
// back end: walks one descriptor a byte per cycle, while out_ready does not stall, into the output register
`default_nettype none
module cfrf_back
  import cfrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire desc_t      desc,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            rejected
);

  logic [4:0] idx;
  logic [4:0] dsel;
  logic       adv;
  logic [7:0] byte_next;
  logic       last_next;

  always_comb begin
    adv  = q_valid && (!out_valid || out_ready);
    dsel = idx - {2'b0, desc.hdr_cnt};
    if (desc.rejected) begin
      byte_next = REJ_BYTE;
      last_next = 1'b1;
    end else begin
      if (idx < {2'b0, desc.hdr_cnt}) begin
        byte_next = desc.hdr[idx[2:0]];
      end else begin
        byte_next = desc.data[dsel[3:0]];
      end
      last_next = (idx == desc.total - 5'd1);
    end
    pop = adv && last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        idx       <= last_next ? 5'd0 : idx + 5'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= byte_next;
      last     <= last_next;
      rejected <= desc.rejected;
    end
  end

endmodule
`default_nettype wire

// ===== sv/can_frame_radio_framer.sv =====
// top level of the can frame radio framer
// the first byte of a frame passes through the queue entry and then the output register
// throughput: one byte per cycle while out_ready does not stall; a frame is 2 + extended bytes + length bytes
//   (2 to 20), a rejected frame a single byte; the rate is set by the byte-wide output register
// frames follow each other with no gap; the two-entry queue takes new frames meanwhile
// reset clears the queue pointers, the byte counter and output valid
`default_nettype none
module can_frame_radio_framer
  import cfrf_pkg::*;
#(
  parameter int MAX_STD_DATA      = 8,
  parameter int MAX_OVERSIZE_DATA = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [10:0] base_id,
  input  wire logic [17:0] ext_id,
  input  wire logic [4:0]  data_len,
  input  wire logic [63:0] data_low,
  input  wire logic [55:0] data_high,
  input  wire logic        allow_oversize,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last,
  output logic             rejected
);

  desc_t front_desc;
  desc_t head_desc;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  q_push;

  // front: classify the frame and build its header bytes in the cycle it arrives
  cfrf_front #(
    .MAX_STD_DATA      (MAX_STD_DATA),
    .MAX_OVERSIZE_DATA (MAX_OVERSIZE_DATA)
  ) u_front (
    .base_id        (base_id),
    .ext_id         (ext_id),
    .data_len       (data_len),
    .data_low       (data_low),
    .data_high      (data_high),
    .allow_oversize (allow_oversize),
    .desc           (front_desc)
  );

  // a transaction is taken whenever the queue has a free slot
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  cfrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_desc   (front_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_desc   (head_desc)
  );

  // back: serialise the head frame; pops on the cycle its last byte is loaded
  cfrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .desc      (head_desc),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .rejected  (rejected)
  );

  // a rejection is always a single zero byte carrying the last mark
  a_rej_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> last && (out_byte == REJ_BYTE))
    else $error("rejection result malformed");

  // the back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // backpressure on the input only when frames are waiting
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

  // nothing is offered straight after reset
  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
